// File: hdl/stik_pkg.sv
// ----------------------------------------------------------------------------
// stik_pkg: shared types for the sorted top-k insertion table
// Holds the command codes, the transfer payloads, the stored entry layout,
// the sequencer states and the status bundle from sequencer to top level.
// ----------------------------------------------------------------------------
package stik_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] name_tag;
    logic [31:0] play_time;
    logic [31:0] move_count;
    logic [31:0] stamp;
    logic [31:0] now_time;
    logic [3:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  position;
    logic [15:0] out_name_tag;
    logic [31:0] out_play_time;
    logic [31:0] out_move_count;
    logic [31:0] out_stamp;
    logic [4:0]  fill_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] play_time;
    logic [31:0] move_count;
    logic [31:0] stamp;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_PLACE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_READ_RD,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ctrl_stat_t;

endpackage

// File: hdl/stik_ram.sv
// ----------------------------------------------------------------------------
// stik_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module stik_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/stik_ctrl.sv
// ----------------------------------------------------------------------------
// stik_ctrl: command sequencer with one shared key comparator
// Scans the table one entry at a time for the insertion slot, then moves
// later entries down one at a time through the RAM and writes the new record.
// ----------------------------------------------------------------------------
module stik_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  stik_pkg::in_item_t        item,
  input  logic                      key_by_time,
  input  logic                      take,
  output stik_pkg::ctrl_stat_t      stat,
  output stik_pkg::out_item_t       result,
  output logic                      ram_we,
  output logic [$clog2(DEPTH)-1:0]  ram_waddr,
  output stik_pkg::entry_t          ram_wdata,
  output logic [$clog2(DEPTH)-1:0]  ram_raddr,
  input  stik_pkg::entry_t          ram_rdata
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  stik_pkg::state_t    state_r, state_nxt;
  stik_pkg::in_item_t  item_r, item_nxt;
  stik_pkg::out_item_t res_r, res_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       slot_r, slot_nxt;
  logic [IW-1:0]       j_r, j_nxt;

  logic                full;
  logic                key_less;
  logic [IW-1:0]       last;
  logic [IW-1:0]       j_dec;
  logic                ridx_ok;

  assign full     = (count_r == CW'(DEPTH));
  assign last     = full ? IW'(DEPTH - 1) : count_r[IW-1:0];
  assign j_dec    = j_r - IW'(1);
  assign ridx_ok  = ((CW + 4)'(item.read_index) < (CW + 4)'(count_r));
  // Shared comparator: new key strictly below the stored key.
  assign key_less = key_by_time ? (item_r.play_time < ram_rdata.play_time)
                                : (item_r.move_count < ram_rdata.move_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stik_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    res_r  <= res_nxt;
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    j_r    <= j_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    slot_nxt  = slot_r;
    j_nxt     = j_r;
    ram_we    = 1'b0;
    ram_waddr = j_r;
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[IW-1:0];

    case (state_r)
      stik_pkg::ST_IDLE: begin
        if (start) begin
          item_nxt = item;
          res_nxt  = '0;
          idx_nxt  = '0;
          case (item.command)
            stik_pkg::CMD_ADD: begin
              state_nxt = stik_pkg::ST_SCAN_RD;
            end
            stik_pkg::CMD_QUERY: begin
              state_nxt = full ? stik_pkg::ST_DONE : stik_pkg::ST_SCAN_RD;
            end
            stik_pkg::CMD_READ: begin
              state_nxt = ridx_ok ? stik_pkg::ST_READ_RD : stik_pkg::ST_DONE;
            end
            default: begin
              // clear: drop the count, keep the contents
              count_nxt  = '0;
              res_nxt.ok = 1'b1;
              state_nxt  = stik_pkg::ST_DONE;
            end
          endcase
        end
      end

      stik_pkg::ST_SCAN_RD: begin
        if (idx_r == count_r) begin
          slot_nxt  = idx_r;
          state_nxt = stik_pkg::ST_PLACE;
        end else begin
          state_nxt = stik_pkg::ST_SCAN_CMP;
        end
      end

      stik_pkg::ST_SCAN_CMP: begin
        if (key_less) begin
          slot_nxt  = idx_r;
          state_nxt = stik_pkg::ST_PLACE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = stik_pkg::ST_SCAN_RD;
        end
      end

      stik_pkg::ST_PLACE: begin
        j_nxt = last;
        if (slot_r == CW'(DEPTH)) begin
          state_nxt = stik_pkg::ST_DONE;
        end else if (item_r.command == stik_pkg::CMD_QUERY) begin
          res_nxt.ok       = 1'b1;
          res_nxt.position = 4'(slot_r);
          state_nxt        = stik_pkg::ST_DONE;
        end else if (CW'(last) > slot_r) begin
          state_nxt = stik_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = stik_pkg::ST_INSERT;
        end
      end

      stik_pkg::ST_SHIFT_RD: begin
        ram_raddr = j_dec;
        state_nxt = stik_pkg::ST_SHIFT_WR;
      end

      stik_pkg::ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = ram_rdata;
        j_nxt     = j_dec;
        state_nxt = (CW'(j_dec) == slot_r) ? stik_pkg::ST_INSERT : stik_pkg::ST_SHIFT_RD;
      end

      stik_pkg::ST_INSERT: begin
        ram_we               = 1'b1;
        ram_waddr            = slot_r[IW-1:0];
        ram_wdata.tag        = item_r.name_tag;
        ram_wdata.play_time  = item_r.play_time;
        ram_wdata.move_count = item_r.move_count;
        ram_wdata.stamp      = (item_r.stamp != '0) ? item_r.stamp : item_r.now_time;
        if (!full) begin
          count_nxt = count_r + CW'(1);
        end
        res_nxt.ok       = 1'b1;
        res_nxt.position = 4'(slot_r);
        state_nxt        = stik_pkg::ST_DONE;
      end

      stik_pkg::ST_READ_RD: begin
        ram_raddr = IW'(item_r.read_index);
        state_nxt = stik_pkg::ST_READ_WAIT;
      end

      stik_pkg::ST_READ_WAIT: begin
        res_nxt.ok             = 1'b1;
        res_nxt.out_name_tag   = ram_rdata.tag;
        res_nxt.out_play_time  = ram_rdata.play_time;
        res_nxt.out_move_count = ram_rdata.move_count;
        res_nxt.out_stamp      = ram_rdata.stamp;
        state_nxt              = stik_pkg::ST_DONE;
      end

      stik_pkg::ST_DONE: begin
        if (take) begin
          state_nxt = stik_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = stik_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    result            = res_r;
    result.fill_count = 5'(count_r);
  end

  assign stat.busy = (state_r != stik_pkg::ST_IDLE);
  assign stat.done = (state_r == stik_pkg::ST_DONE);

endmodule

// File: hdl/sorted_topk_insert_table_top.sv
// ----------------------------------------------------------------------------
// sorted_topk_insert_table_top: sorted top-k record table
// Keeps up to DEPTH records in ascending key order with stable ties and
// serves add, can-add, read and clear commands one at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_item: one command per transfer.
//   Result channel out_valid / out_stall / out_item: exactly one result per
//   command, in command order. Config port cfg_wr_en / cfg_wr_data writes
//   key_by_time (1 = order by play time, 0 = by move count); write it only
//   while the block is idle.
//   Work per command: an add compares S entries and moves M entries down,
//   and a refused add on a full table compares all DEPTH entries; a query
//   compares S entries, or none on a full table; a read does one RAM read;
//   clear and a read past the fill level finish without touching the RAM.
//   The table sits in a single RAM with one read and one write port, and one
//   key comparator walks it one entry at a time.
//   in_stall stays high from accept until the result moves into the output
//   register, so one command is in flight at a time.
//   A stall on the result side holds out_item; the next command can still be
//   taken while the result waits there.
//   Reset empties the table (count to zero) and sets key_by_time to 1; no
//   RAM clearing pass is needed, since entries past the count are never read.
// ----------------------------------------------------------------------------
module sorted_topk_insert_table_top #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stik_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output stik_pkg::out_item_t out_item,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  localparam int IW = $clog2(DEPTH);

  stik_pkg::ctrl_stat_t stat;
  stik_pkg::out_item_t  res;
  stik_pkg::out_item_t  out_item_r;
  stik_pkg::entry_t     ram_wdata;
  stik_pkg::entry_t     ram_rdata;
  logic [IW-1:0]        ram_waddr;
  logic [IW-1:0]        ram_raddr;
  logic                 ram_we;
  logic                 key_by_time_r;
  logic                 out_valid_r;
  logic                 start;
  logic                 take;

  // Accept a command only while the sequencer is idle.
  assign in_stall = stat.busy;
  assign start    = in_valid && !stat.busy;

  // Move a finished result into the output register once it is free.
  assign take = stat.done && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_by_time_r <= 1'b1;
    end else if (cfg_wr_en) begin
      key_by_time_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while stalled; load only on a new result.
  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  stik_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .item        (in_item),
    .key_by_time (key_by_time_r),
    .take        (take),
    .stat        (stat),
    .result      (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  stik_ram #(
    .WIDTH (stik_pkg::EntryW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  // An accepted command keeps the sequencer busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> stat.busy)
    else $error("sequencer not busy after accepting a command");

  // A new result appears only after the sequencer finished a command.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(stat.done))
    else $error("result appeared without a finished command");

  // A rejected command reports slot zero and no entry data.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.ok) |->
      (out_item_r.position == 4'd0 && out_item_r.out_name_tag == 16'd0))
    else $error("failed command carries nonzero position or data");
`endif

endmodule

// File: test/tb_sorted_topk_insert_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_topk_insert_table_top: self-checking bench for the top-k table
// Drives add, can-add, read and clear commands under both key orders. A
// directed walk covers the empty table, extreme keys, ties, a full table and
// evictions. Random phases follow, each with its own key order. Results are
// checked against a local model of the sorted table, with random idling on
// both channels and one long hold on the result side.
// ----------------------------------------------------------------------------
module tb_sorted_topk_insert_table_top;

  localparam int DEPTH       = 16;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 225;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 80;

  // One row of the directed walk: either a key-order write or a command,
  // the latter with an optional hand-written result.
  typedef struct {
    bit                  is_cfg;
    bit                  cfg_val;
    stik_pkg::in_item_t  item;
    bit                  typed;
    stik_pkg::out_item_t res;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  stik_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_stall;
  stik_pkg::out_item_t out_item;
  logic                cfg_wr_en;
  logic                cfg_wr_data;

  // Local copy of the table: entries, fill level and key order.
  stik_pkg::entry_t    tbl [DEPTH];
  int                  tbl_count;
  bit                  order_by_time;

  stik_pkg::out_item_t results_due [$];
  dir_row_t            dir_rows [$];

  bit        quiet;
  int        fail_count;
  int        n_checked;
  int        n_cmd [4];
  int        n_evicted;
  int        n_refused;
  int        n_cfg;
  int        idle_run;

  sorted_topk_insert_table_top #(
    .DEPTH(DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // First slot whose key is strictly above the new key; equal keys land after
  // the entries already there, which keeps ties in arrival order.
  function automatic int first_greater(logic [31:0] t, logic [31:0] m);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (order_by_time ? (t < tbl[i].play_time) : (m < tbl[i].move_count)) break;
    end
    return i;
  endfunction

  // Apply one command to the model and return the result it must produce.
  function automatic stik_pkg::out_item_t apply_cmd(stik_pkg::in_item_t it);
    stik_pkg::out_item_t r;
    int        slot;
    int        j;
    int        last_slot;
    r = '0;
    case (it.command)
      stik_pkg::CMD_ADD: begin
        slot = first_greater(it.play_time, it.move_count);
        if (slot < DEPTH) begin
          last_slot = (tbl_count >= DEPTH) ? DEPTH - 1 : tbl_count;
          // shift later entries down; the tail falls off a full table
          for (j = last_slot; j > slot; j--) tbl[j] = tbl[j-1];
          tbl[slot].tag        = it.name_tag;
          tbl[slot].play_time  = it.play_time;
          tbl[slot].move_count = it.move_count;
          // a zero stamp takes the current time instead
          tbl[slot].stamp      = (it.stamp != 0) ? it.stamp : it.now_time;
          if (tbl_count < DEPTH) tbl_count++;
          r.ok       = 1'b1;
          r.position = slot[3:0];
        end
      end
      stik_pkg::CMD_QUERY: begin
        if (tbl_count < DEPTH) begin
          slot       = first_greater(it.play_time, it.move_count);
          r.ok       = 1'b1;
          r.position = slot[3:0];
        end
      end
      stik_pkg::CMD_READ: begin
        if (it.read_index < tbl_count) begin
          r.ok             = 1'b1;
          r.out_name_tag   = tbl[it.read_index].tag;
          r.out_play_time  = tbl[it.read_index].play_time;
          r.out_move_count = tbl[it.read_index].move_count;
          r.out_stamp      = tbl[it.read_index].stamp;
        end
      end
      default: begin
        // clear: contents stay but drop out of reach
        tbl_count = 0;
        r.ok      = 1'b1;
      end
    endcase
    r.fill_count = tbl_count[4:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic stik_pkg::in_item_t mk_item(stik_pkg::cmd_t c, logic [15:0] tag,
                                                 logic [31:0] t, logic [31:0] m,
                                                 logic [31:0] st, logic [31:0] now,
                                                 logic [3:0] idx);
    stik_pkg::in_item_t it;
    it.command    = c;
    it.name_tag   = tag;
    it.play_time  = t;
    it.move_count = m;
    it.stamp      = st;
    it.now_time   = now;
    it.read_index = idx;
    return it;
  endfunction

  // Result of a command that returns no entry.
  function automatic stik_pkg::out_item_t mk_status(bit ok, logic [3:0] pos,
                                                    logic [4:0] fill);
    stik_pkg::out_item_t r;
    r            = '0;
    r.ok         = ok;
    r.position   = pos;
    r.fill_count = fill;
    return r;
  endfunction

  function automatic void push_row(stik_pkg::in_item_t it, bit typed,
                                   stik_pkg::out_item_t res);
    dir_row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_val = 1'b0;
    r.item    = it;
    r.typed   = typed;
    r.res     = res;
    dir_rows.push_back(r);
  endfunction

  function automatic void push_cfg(bit v);
    dir_row_t r;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    r.item    = '0;
    r.typed   = 1'b0;
    r.res     = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    int i;
    // empty table right after reset
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd0), 1, mk_status(0, 0, 0));
    push_row(mk_item(stik_pkg::CMD_QUERY, 16'h0000, 5, 5, 0, 0, 4'd0), 1, mk_status(1, 0, 0));
    push_row(mk_item(stik_pkg::CMD_CLEAR, 16'h0000, 0, 0, 0, 0, 4'd0), 1, mk_status(1, 0, 0));
    // extreme keys; the second record takes its stamp from the current time
    push_row(mk_item(stik_pkg::CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                     4'hF), 1, mk_status(1, 0, 1));
    push_row(mk_item(stik_pkg::CMD_ADD, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                     4'h0), 1, mk_status(1, 0, 2));
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd0), 0, '0);
    // read past the fill level
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd15), 1, mk_status(0, 0, 2));
    // fill up with repeated keys so ties pile up in arrival order
    for (i = 0; i < DEPTH - 2; i++) begin
      push_row(mk_item(stik_pkg::CMD_ADD, 16'(i + 1), 32'((i % 5) * 100 + 1),
                       32'(1000 - 7 * i), (i % 3 == 0) ? 32'h0 : 32'(50 + i),
                       32'(9000 + i), 4'd0), 0, '0);
    end
    // full table: query refused, add with a key not below the tail refused
    push_row(mk_item(stik_pkg::CMD_QUERY, 16'h0000, 0, 0, 0, 0, 4'd0), 1, mk_status(0, 0, 16));
    push_row(mk_item(stik_pkg::CMD_ADD, 16'hABCD, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h1,
                     4'd0), 1, mk_status(0, 0, 16));
    // smaller key evicts the tail
    push_row(mk_item(stik_pkg::CMD_ADD, 16'h1234, 32'h1, 32'h5, 32'h0, 32'h77, 4'd0), 0, '0);
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd15), 0, '0);
    // order by move count on the same contents
    push_row(mk_item(stik_pkg::CMD_ADD, 16'h5555, 32'h0, 32'h0, 32'h3, 32'h3, 4'd0), 0, '0);
    push_cfg(1'b0);
    push_row(mk_item(stik_pkg::CMD_ADD, 16'hAAAA, 32'hFFFF_FFFF, 32'h0, 32'h3, 32'h3,
                     4'd0), 0, '0);
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd0), 0, '0);
    push_row(mk_item(stik_pkg::CMD_CLEAR, 16'h0000, 0, 0, 0, 0, 4'd0), 1, mk_status(1, 0, 0));
    push_row(mk_item(stik_pkg::CMD_READ, 16'h0000, 0, 0, 0, 0, 4'd0), 1, mk_status(0, 0, 0));
    push_cfg(1'b1);
  endfunction

  // Keys lean on small values to force ties, with the extremes mixed in.
  function automatic logic [31:0] rand_key();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(0, 31);
    if (r < 8) return $urandom_range(0, 1000);
    return $urandom;
  endfunction

  function automatic stik_pkg::in_item_t random_cmd();
    stik_pkg::in_item_t it;
    int       r;
    it            = '0;
    it.name_tag   = 16'($urandom);
    it.play_time  = rand_key();
    it.move_count = rand_key();
    it.stamp      = ($urandom_range(0, 4) == 0) ? 32'h0 : $urandom;
    it.now_time   = $urandom;
    // mostly reads within the fill level, some past it
    if (tbl_count > 0 && $urandom_range(0, 4) != 0)
      it.read_index = 4'($urandom_range(0, tbl_count - 1));
    else
      it.read_index = 4'($urandom_range(0, 15));
    // clears are rare so the table spends time full
    r = $urandom_range(0, 99);
    if (r < 58)      it.command = stik_pkg::CMD_ADD;
    else if (r < 72) it.command = stik_pkg::CMD_QUERY;
    else if (r < 98) it.command = stik_pkg::CMD_READ;
    else             it.command = stik_pkg::CMD_CLEAR;
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel
  // --------------------------------------------------------------------------

  // Offer one command, wait for the transfer, log its expected result.
  // Entered and left at a falling edge.
  task automatic issue(stik_pkg::in_item_t it, bit typed, stik_pkg::out_item_t typed_res);
    int        gap;
    bit        was_full;
    stik_pkg::out_item_t predicted;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    was_full  = (tbl_count == DEPTH);
    predicted = apply_cmd(it);
    results_due.push_back(typed ? typed_res : predicted);
    n_cmd[it.command]++;
    if (it.command == stik_pkg::CMD_ADD && was_full && predicted.ok) n_evicted++;
    if (!predicted.ok) n_refused++;
    @(negedge clk);
  endtask

  // Change the key order once the block has gone quiet.
  task automatic set_order(bit v);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    order_by_time = v;
    n_cfg++;
  endtask

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------

  task automatic field_diff(string name, logic [31:0] e, logic [31:0] g);
    if (g !== e) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, g);
      fail_count++;
    end
  endtask

  task automatic take_result(stik_pkg::out_item_t got);
    stik_pkg::out_item_t want;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      fail_count++;
      return;
    end
    want = results_due.pop_front();
    field_diff("ok", 32'(want.ok), 32'(got.ok));
    field_diff("position", 32'(want.position), 32'(got.position));
    field_diff("out_name_tag", 32'(want.out_name_tag), 32'(got.out_name_tag));
    field_diff("out_play_time", want.out_play_time, got.out_play_time);
    field_diff("out_move_count", want.out_move_count, got.out_move_count);
    field_diff("out_stamp", want.out_stamp, got.out_stamp);
    field_diff("fill_count", 32'(want.fill_count), 32'(got.fill_count));
    n_checked++;
  endtask

  // Sample at the rising edge, decide the stall at the falling edge. Stall
  // comes in short bursts, with calm stretches in between, and once in the
  // run a long hold lets the block back up onto its input.
  initial begin
    int  stall_left;
    int  cyc;
    int  k;
    bit  stall_mode;
    bit  held_long;
    out_stall  = 1'b0;
    stall_left = 0;
    cyc        = 0;
    stall_mode = 1'b1;
    held_long  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) take_result(out_item);
      @(negedge clk);
      if (!held_long && n_checked >= 300) begin
        held_long = 1'b1;
        out_stall <= 1'b1;
        for (k = 0; k < LONG_HOLD; k++) @(negedge clk);
      end
      cyc++;
      if (cyc % 128 == 0) stall_mode = ($urandom_range(0, 2) != 0);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_mode && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transfer happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("** sorted_topk_insert_table_top: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    int p;
    int n;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    rst_n         = 1'b0;
    quiet         = 1'b0;
    fail_count    = 0;
    n_checked     = 0;
    n_evicted     = 0;
    n_refused     = 0;
    n_cfg         = 0;
    idle_run      = 0;
    n_cmd         = '{default: 0};
    tbl           = '{default: '0};
    tbl_count     = 0;
    order_by_time = 1'b1;   // reset value of the key order
    build_directed();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed walk
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_cfg) set_order(dir_rows[i].cfg_val);
      else issue(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    end

    // random phases, alternating key order; the last one runs without idling
    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) quiet = 1'b1;
      set_order(1'(p % 2));
      for (n = 0; n < PHASE_ITEMS; n++) issue(random_cmd(), 1'b0, '0);
    end

    // drain, then give a stray result time to show up
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d adds, %0d can-add queries, %0d reads, %0d clears; %0d results",
             n_cmd[stik_pkg::CMD_ADD], n_cmd[stik_pkg::CMD_QUERY],
             n_cmd[stik_pkg::CMD_READ], n_cmd[stik_pkg::CMD_CLEAR], n_checked);
    $display("Full-table evictions %0d, refused commands %0d, key order writes %0d",
             n_evicted, n_refused, n_cfg);
    if (fail_count == 0) begin
      $display("** sorted_topk_insert_table_top: PASSED **");
    end else begin
      $display("** sorted_topk_insert_table_top: FAILED **");
    end
    $finish;
  end

endmodule
